// ===== src/signed_int_to_decimal_ascii_core_defines.svh =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII - assertion macros
// Shared concurrent-check shorthands, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants, types and helpers of the signed integer to ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

  // Default operand width
  localparam int VALUE_WIDTH_DEF = 32;

  // Character field
  localparam int            CHAR_W      = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // Decimal digits of 2**w - 1: floor(w * log10(2)) + 1, log10(2) ~ 1233/4096
  function automatic int num_digits(input int w);
    num_digits = ((w * 1233) >> 12) + 1;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture operand, clear BCD
    logic step;       // one add-3 / shift step
    logic rot;        // advance to next digit
    logic put_sign;   // drive '-' beat
    logic put_digit;  // drive top digit beat
    logic last;       // last flag for the digit beat
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic neg;        // operand was negative
    logic top_zero;   // current top digit is zero
  } sts_t;

endpackage

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_core.sv =====
// Sequence: VALUE_WIDTH add-3/shift steps, a sign beat if the value is negative, then
//   NumDigits digit steps (10 at width 32); beats are registered.
// busy is high through the whole conversion and start is taken only in idle, so a new
//   value is accepted only after the previous value's last digit beat has been issued.
// Reset: synchronous active-low rst_n returns to idle and drops out_strobe.
// The receiver cannot stall; each beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer to its decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                               out_strobe,
  output logic [sitda_pkg::CHAR_W-1:0]       out_character,
  output logic                               out_last
);

  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  sitda_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sitda_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== src/sitda_dpath.sv =====
// ----------------------------------------------------------------------------
// sitda_dpath
// Magnitude shift register, BCD digit register and registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_dpath #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  input  wire sitda_pkg::cmd_t             cmd,
  output sitda_pkg::sts_t                  sts,
  output logic                             out_strobe,
  output logic [sitda_pkg::CHAR_W-1:0]     out_character,
  output logic                             out_last
);

  localparam int NumDigits = sitda_pkg::num_digits(VALUE_WIDTH);
  localparam int BcdW      = NumDigits * 4;

  logic [VALUE_WIDTH-1:0]        mag_r, mag_nxt;
  logic [BcdW-1:0]               bcd_r, bcd_nxt;
  logic                          neg_r, neg_nxt;
  logic [BcdW-1:0]               bcd_adj;
  logic [VALUE_WIDTH-1:0]        in_raw;
  logic [3:0]                    top_digit;
  logic                          strobe_r, strobe_nxt;
  logic [sitda_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                          last_r, last_nxt;

  assign in_raw    = in_value;
  assign top_digit = bcd_r[BcdW-1 -: 4];

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  // Operand and digit registers
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      neg_nxt = in_raw[VALUE_WIDTH-1];
      mag_nxt = in_raw[VALUE_WIDTH-1] ? (~in_raw + 1'b1) : in_raw;
      bcd_nxt = '0;
    end else if (cmd.step) begin
      bcd_nxt = {bcd_adj[BcdW-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.rot) begin
      bcd_nxt = {bcd_r[BcdW-5:0], 4'b0000};
    end
  end

  // Output beat
  always_comb begin
    strobe_nxt = cmd.put_sign | cmd.put_digit;
    char_nxt   = char_r;
    last_nxt   = last_r;
    if (cmd.put_sign) begin
      char_nxt = sitda_pkg::ASCII_MINUS;
      last_nxt = 1'b0;
    end else if (cmd.put_digit) begin
      char_nxt = sitda_pkg::ASCII_ZERO + {2'b00, top_digit};
      last_nxt = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  assign sts.neg      = neg_r;
  assign sts.top_zero = (top_digit == 4'd0);

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// ===== src/sitda_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: conversion step count, sign beat, digit walk with zero skip.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_core_defines.svh"

module sitda_ctrl #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire sitda_pkg::sts_t  sts,
  output sitda_pkg::cmd_t       cmd
);

  localparam int NumDigits = sitda_pkg::num_digits(VALUE_WIDTH);
  localparam int CntW      = $clog2(VALUE_WIDTH);
  localparam int DcntW     = $clog2(NumDigits);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DcntW-1:0] dcnt_r, dcnt_nxt;
  logic             seen_r, seen_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dcnt_nxt  = dcnt_r;
    seen_nxt  = seen_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CntW'(VALUE_WIDTH - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dcnt_nxt  = DcntW'(NumDigits - 1);
          seen_nxt  = 1'b0;
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd.put_sign = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        // leading zeros are dropped, the units digit always goes out
        cmd.rot  = 1'b1;
        dcnt_nxt = dcnt_r - 1'b1;
        if (!sts.top_zero || seen_r || (dcnt_r == '0)) begin
          cmd.put_digit = 1'b1;
          cmd.last      = (dcnt_r == '0);
          seen_nxt      = 1'b1;
        end
        if (dcnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dcnt_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dcnt_r  <= dcnt_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Checks
  `SITDA_ASSERT_NEXT(a_start_conv, (state_r == ST_IDLE) && start, state_r == ST_CONV, "accepted beat did not start conversion")
  `SITDA_ASSERT_NEXT(a_last_idle, cmd.put_digit && cmd.last, state_r == ST_IDLE, "controller not idle after last beat")
  `SITDA_ASSERT_NOW(a_sign_neg, cmd.put_sign, sts.neg, "sign beat for non-negative operand")
  `SITDA_ASSERT_NOW(a_one_beat, cmd.put_sign, !cmd.put_digit && !cmd.rot, "sign and digit beat together")

endmodule

`default_nettype wire

// ===== tb/tb_signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Drives signed 32-bit values through the start/busy command port and checks
// every character beat (character and last flag) against a predicted decimal
// text. The directed values cover zero, single digits, powers of ten, both
// extremes and alternating bit patterns. Random values then mix full-range
// words, values of chosen digit counts, powers of ten and near-extreme values,
// with random gaps between commands.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW           = sitda_pkg::VALUE_WIDTH_DEF;
  localparam int CW           = sitda_pkg::CHAR_W;
  localparam int NUM_RANDOM   = 380;
  localparam int TAIL_CYCLES  = 60;
  localparam int LIMIT_CYCLES = 400000;

  // One predicted character beat
  typedef struct {
    logic [CW-1:0] character;
    logic          last;
  } char_beat_t;

  // One queued command with the idle cycles that come before it
  typedef struct {
    logic signed [VW-1:0] value;
    int unsigned          gap;
  } value_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [VW-1:0] in_value;
  logic                 out_strobe;
  logic [CW-1:0]        out_character;
  logic                 out_last;

  value_cmd_t value_q[$];
  char_beat_t char_q[$];
  int         err_cnt   = 0;
  int         cycle_cnt = 0;
  int         idle_cnt  = 0;
  bit         drive_en  = 1'b0;
  bit         took_beat = 1'b0;

  signed_int_to_decimal_ascii_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Expected text of one value: optional minus, then digits MSD first
  function automatic void predict_text(input logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [3:0]    digs[$];
    char_beat_t    b;
    bit            neg;
    neg = v[VW-1];
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digs.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      b.character = sitda_pkg::ASCII_MINUS;
      b.last      = 1'b0;
      char_q.push_back(b);
    end
    foreach (digs[i]) begin
      b.character = sitda_pkg::ASCII_ZERO + CW'(digs[i]);
      b.last      = (i == digs.size() - 1);
      char_q.push_back(b);
    end
  endfunction

  // Idle cycles before a command: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 15);
    else return $urandom_range(20, 60);
  endfunction

  // Driver: hold start until the beat is taken, then move to the next command
  always @(negedge clk) begin
    if (drive_en) begin
      if (!start || took_beat) begin
        took_beat = 1'b0;
        if (value_q.size() != 0 && idle_cnt >= value_q[0].gap) begin
          idle_cnt = 0;
          in_value <= value_q[0].value;
          start    <= 1'b1;
          void'(value_q.pop_front());
        end else begin
          if (value_q.size() != 0) idle_cnt++;
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result beats first, then predict any accepted command
  always @(posedge clk) begin
    char_beat_t exp_beat;
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_strobe) begin
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=%0d last=%0b",
                                    out_character, out_last));
        end else begin
          exp_beat = char_q.pop_front();
          if (out_character !== exp_beat.character)
            report_mismatch($sformatf("character got %0d exp %0d",
                                      out_character, exp_beat.character));
          if (out_last !== exp_beat.last)
            report_mismatch($sformatf("last got %0b exp %0b (char %0d)",
                                      out_last, exp_beat.last, exp_beat.character));
        end
      end
      if (start && !busy) begin
        predict_text(in_value);
        took_beat = 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int          dir_vals[20];
    value_cmd_t  cmd;
    longint      mag;
    longint      p10;
    longint      lo;
    longint      hi;
    int unsigned sel;
    int unsigned nd;
    int unsigned burst_left;
    bit          neg;

    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;

    // Directed: zero, digit counts, powers of ten, both extremes, bit patterns
    dir_vals = '{0, 1, -1, 7, -9, 10, -10, 99, -100, 12345, 1000000000, 999999999,
                 -999999999, 1000000001, 2147483647, -2147483647, 32'h8000_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, -2147483640};
    foreach (dir_vals[i]) begin
      cmd.value = dir_vals[i];
      cmd.gap   = (i < 6) ? 0 : pick_gap();
      value_q.push_back(cmd);
    end

    // Random values with occasional gapless bursts
    burst_left = 0;
    repeat (NUM_RANDOM) begin
      sel = $urandom_range(0, 99);
      neg = $urandom_range(0, 1);
      if (sel < 40) begin
        cmd.value = $urandom;
      end else begin
        if (sel < 75) begin
          // uniform digit count, random value of that length
          nd  = $urandom_range(1, 10);
          p10 = 1;
          repeat (nd - 1) p10 *= 10;
          lo  = (nd == 1) ? 0 : p10;
          hi  = p10 * 10 - 1;
          if (hi > 64'd2147483648) hi = 64'd2147483648;
          mag = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
        end else if (sel < 90) begin
          // power of ten and its neighbors
          p10 = 1;
          repeat ($urandom_range(0, 9)) p10 *= 10;
          mag = p10 + $urandom_range(0, 2) - 1;
        end else if (sel < 95) begin
          mag = 64'd2147483648 - $urandom_range(0, 20);
        end else begin
          mag = $urandom_range(0, 5);
        end
        if (mag == 64'd2147483648) neg = 1'b1;
        cmd.value = neg ? VW'(-mag) : VW'(mag);
      end
      if (burst_left != 0) begin
        burst_left--;
        cmd.gap = 0;
      end else if ($urandom_range(0, 99) < 8) begin
        burst_left = $urandom_range(10, 30);
        cmd.gap    = 0;
      end else begin
        cmd.gap = pick_gap();
      end
      value_q.push_back(cmd);
    end

    // Hold reset, release it, then enable the driver
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drive_en = 1'b1;

    while (value_q.size() != 0 || start) @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (char_q.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", char_q.size()));
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
